### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is checked at every edge, reset included.
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/mmce_pkg.sv
// ----------------------------------------------------------------------------
// mmce_pkg
// Types, constants and small helpers of the multi-mode CRC engine.
// ----------------------------------------------------------------------------
package mmce_pkg;

  typedef enum logic [1:0] {
    MODE_REFL16 = 2'd0,
    MODE_CRC8   = 2'd1,
    MODE_CCITT  = 2'd2
  } crc_mode_t;

  localparam logic [15:0] POLY_REFL16 = 16'hA001;
  localparam logic [7:0]  POLY_CRC8   = 8'hB5;
  localparam logic [15:0] POLY_CCITT  = 16'h1021;
  localparam logic [15:0] INIT16      = 16'hFFFF;
  localparam logic [7:0]  INIT8       = 8'hFF;

  // Register index of the mode register.
  localparam logic REG_CRC_MODE = 1'b0;

  // The unused mode code behaves as the reflected CRC-16.
  function automatic crc_mode_t eff_mode(input logic [1:0] raw);
    crc_mode_t m;
    case (raw)
      2'd1:    m = MODE_CRC8;
      2'd2:    m = MODE_CCITT;
      default: m = MODE_REFL16;
    endcase
    return m;
  endfunction

  function automatic logic [15:0] init_value(input logic [1:0] raw);
    return (eff_mode(raw) == MODE_CRC8) ? {8'h00, INIT8} : INIT16;
  endfunction

endpackage

### sv/mmce_fold.sv
// ----------------------------------------------------------------------------
// mmce_fold
// Folds one byte into the running CRC with eight shift-xor steps.
// ----------------------------------------------------------------------------
module mmce_fold
  import mmce_pkg::*;
(
  input  crc_mode_t   mode,
  input  logic [15:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [15:0] crc_out
);

  always_comb begin
    logic [15:0] c16;
    logic [7:0]  c8;
    c16     = '0;
    c8      = '0;
    crc_out = '0;
    case (mode)
      MODE_REFL16: begin
        c16 = crc_in ^ {8'h00, data_in};
        for (int k = 0; k < 8; k++) begin
          c16 = c16[0] ? ((c16 >> 1) ^ POLY_REFL16) : (c16 >> 1);
        end
        crc_out = c16;
      end
      MODE_CRC8: begin
        c8 = crc_in[7:0] ^ data_in;
        for (int k = 0; k < 8; k++) begin
          c8 = c8[7] ? ((c8 << 1) ^ POLY_CRC8) : (c8 << 1);
        end
        crc_out = {8'h00, c8};
      end
      MODE_CCITT: begin
        c16 = crc_in ^ {data_in, 8'h00};
        for (int k = 0; k < 8; k++) begin
          c16 = c16[15] ? ((c16 << 1) ^ POLY_CCITT) : (c16 << 1);
        end
        crc_out = c16;
      end
      default: begin
        crc_out = crc_in;
      end
    endcase
  end

endmodule

### sv/multi_mode_crc_engine.sv
// ----------------------------------------------------------------------------
// multi_mode_crc_engine
// Byte-serial CRC engine with three selectable CRC schemes.
// ----------------------------------------------------------------------------
// The engine takes one message byte per word on the input channel and folds
// it into a running CRC. The mode register (address 0) selects the scheme:
// 0 is the reflected CRC-16 with polynomial 0xA001, 1 is an MSB-first CRC-8
// with polynomial 0xB5, and 2 is CRC-16 CCITT-FALSE (polynomial 0x1021); the
// unused code 3 behaves as mode 0. When the word flagged as last is taken,
// one result word carrying the finished CRC leaves on the output channel and
// the running CRC is reloaded with the init value of the mode. In CRC-8 mode
// the upper eight bits of the result are zero. Any write to the mode register
// also reloads the running CRC, so a partial message is discarded. Throughput
// is one byte per clock while the input is not stalled: all eight shift-xor
// steps of a byte are done combinationally between the running CRC register
// and the result register, and a result reaches the output in the cycle after
// its last byte is taken. The input is stalled only while a finished result
// waits in the output register and the output side is stalling.
// ----------------------------------------------------------------------------
module multi_mode_crc_engine
  import mmce_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_crc_value,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [1:0]  mode_r,      mode_nxt;
  logic [15:0] crc_r,       crc_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_crc_r,   out_crc_nxt;

  logic        cfg_wr;
  logic        mode_wr;
  logic        in_take;
  logic [15:0] folded;

  // The register index is the word address; the byte offset bits are ignored.
  assign cfg_wr  = psel && penable && pwrite;
  assign mode_wr = cfg_wr && (paddr[2] == REG_CRC_MODE);

  assign pready  = 1'b1;
  assign prdata  = (paddr[2] == REG_CRC_MODE) ? {30'd0, mode_r} : 32'd0;

  // A new byte can enter whenever the output register is free or drains now.
  assign in_stall = out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  mmce_fold u_fold (
    .mode    (eff_mode(mode_r)),
    .crc_in  (crc_r),
    .data_in (in_data_byte),
    .crc_out (folded)
  );

  always_comb begin
    mode_nxt      = mode_r;
    crc_nxt       = crc_r;
    out_valid_nxt = out_valid_r;
    out_crc_nxt   = out_crc_r;

    if (mode_wr) begin
      // A mode write restarts the message with the new init value.
      mode_nxt = pwdata[1:0];
      crc_nxt  = init_value(pwdata[1:0]);
    end else if (in_take) begin
      crc_nxt = in_last_byte ? init_value(mode_r) : folded;
    end

    if (in_take && in_last_byte) begin
      out_valid_nxt = 1'b1;
      out_crc_nxt   = folded;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 2'd0;
      crc_r       <= INIT16;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_crc_r <= out_crc_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_crc_value = out_crc_r;

endmodule

### sv/mmce_checker.sv
// ----------------------------------------------------------------------------
// mmce_checker
// Port-level checks of the multi-mode CRC engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mmce_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_data_byte,
  input logic        in_last_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_crc_value,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  logic in_take;
  logic in_last_take;

  assign in_take      = in_valid && !in_stall;
  assign in_last_take = in_take && in_last_byte;

  // A stalled result word stays on the port unchanged.
  `ASSERT_CLK_RST(a_out_hold, clk, rst_n, (out_valid && out_stall) |=> out_valid, "out_valid dropped while stalled")
  `ASSERT_CLK_RST(a_out_stable, clk, rst_n, (out_valid && out_stall) |=> $stable(out_crc_value), "stalled result changed")

  // Taking the last byte of a message always yields a result next cycle.
  `ASSERT_CLK_RST(a_last_gives_result, clk, rst_n, in_last_take |=> out_valid, "no result after the last byte")

  // No result word appears unless a last byte was taken.
  `ASSERT_CLK_RST(a_no_spurious_result, clk, rst_n, (!(out_valid && out_stall) && !in_last_take) |=> !out_valid, "result without a last byte")

  // The input is only held off by a waiting, stalled result.
  `ASSERT_CLK_RST(a_stall_cause, clk, rst_n, in_stall |-> (out_valid && out_stall), "input stalled without a waiting result")

endmodule

bind multi_mode_crc_engine mmce_checker u_mmce_checker (.*);

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multi-mode CRC engine.
// ----------------------------------------------------------------------------
// Message bytes are pushed into the engine one word at a time. A software
// copy of the CRC arithmetic tracks the mode register and the running CRC, so
// every word flagged last queues the CRC that the engine must report. A
// checker compares each result word with the oldest queued CRC. Directed
// tests cover the byte extremes in every mode, the spare mode code, mode
// writes in the middle of a message, writes to an unused register and
// ignored high data bits. Random messages follow, in several mode settings,
// with random gaps on the input side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb;
  import mmce_pkg::*;

  // The spare mode code, which the engine runs as mode 0, and the register index that the engine must ignore.
  localparam logic [1:0] MODE_SPARE  = 2'd3;
  localparam int         REG_UNUSED  = 1;
  localparam int         PHASE_BYTES = 322;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_crc_value;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  multi_mode_crc_engine i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .in_last_byte  (in_last_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_crc_value (out_crc_value),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Shadow copy of the engine state: the raw mode register and the CRC
  // accumulated over the bytes of the current message.
  logic [1:0]  shadow_mode;
  logic [15:0] shadow_crc;
  logic [15:0] pending_crcs[$];

  int unsigned error_count;
  int unsigned bytes_sent;
  int unsigned crcs_checked;
  int unsigned reg_writes;
  int          stall_left;
  bit          quiet;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run, far above the slowest correct run.
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // CRC arithmetic
  // ---------------------------------------------------------------------------

  // The spare code 3 runs the reflected CRC-16.
  function automatic crc_mode_t mode_of(input logic [1:0] raw);
    return (raw == MODE_SPARE) ? MODE_REFL16 : crc_mode_t'(raw);
  endfunction

  function automatic logic [15:0] start_value(input logic [1:0] raw);
    return (mode_of(raw) == MODE_CRC8) ? {8'h00, INIT8} : INIT16;
  endfunction

  // Folds one byte into the CRC with eight shift-xor steps of the given mode.
  function automatic logic [15:0] crc_fold(input logic [1:0] raw, input logic [15:0] crc,
                                           input logic [7:0] data);
    logic [15:0] c;
    logic [7:0]  c8;
    c = crc;
    case (mode_of(raw))
      MODE_CRC8: begin
        c8 = c[7:0] ^ data;
        for (int k = 0; k < 8; k++)
          c8 = c8[7] ? ({c8[6:0], 1'b0} ^ POLY_CRC8) : {c8[6:0], 1'b0};
        c = {8'h00, c8};
      end
      MODE_CCITT: begin
        c = c ^ {data, 8'h00};
        for (int k = 0; k < 8; k++)
          c = c[15] ? ({c[14:0], 1'b0} ^ POLY_CCITT) : {c[14:0], 1'b0};
      end
      default: begin
        c = c ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
          c = c[0] ? ((c >> 1) ^ POLY_REFL16) : (c >> 1);
      end
    endcase
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic flag_error(input string msg);
    error_count++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  // Every result word taken at an edge is matched against the oldest CRC.
  // Values are read in the active region, so they are the ones held before
  // the edge.
  always @(posedge clk) begin : result_check
    logic [15:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_crcs.size() == 0) begin
        flag_error($sformatf("result word 0x%04h with no CRC expected", out_crc_value));
      end else begin
        want = pending_crcs.pop_front();
        crcs_checked++;
        if (out_crc_value !== want)
          flag_error($sformatf("crc_value 0x%04h, expected 0x%04h", out_crc_value, want));
      end
    end
  end

  // The result side may hold stall after each word it takes, so the next
  // result often lands in a stalled output register and pushes back onto the
  // input channel. In quiet stretches it never stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (out_valid && !out_stall && !quiet) begin
      stall_left = $urandom_range(0, 3);
      out_stall <= (stall_left > 0);
      if (stall_left > 0)
        stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Sends one message byte. It is called just after a rising edge and returns
  // just after the edge that took the word, with valid still high, so that
  // back-to-back words need no drop of valid. The shadow state is advanced
  // at the accepting edge.
  task automatic push_byte(input logic [7:0] data, input logic last);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= data;
    in_last_byte <= last;
    // Stall has settled by the falling edge; the next rising edge takes the
    // word once it is seen low there.
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    bytes_sent++;
    shadow_crc = crc_fold(shadow_mode, shadow_crc, data);
    if (last) begin
      pending_crcs.push_back(shadow_crc);
      shadow_crc = start_value(shadow_mode);
    end
  endtask

  // Lowers valid and waits until every queued CRC has come back. A byte that
  // is not last yields no result, so the task also waits for it to settle in
  // the running CRC before anything else happens.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_crcs.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes one register through the APB-style port while the engine is
  // idle, then reads the mode register back.
  task automatic write_reg(input int index, input logic [31:0] value);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(index * 4);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    reg_writes++;
    // Only the mode register exists; it keeps the two low bits and any write
    // to it restarts the running CRC, even with the same mode.
    if (index == int'(REG_CRC_MODE)) begin
      shadow_mode = value[1:0];
      shadow_crc  = start_value(shadow_mode);
    end
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= 3'(int'(REG_CRC_MODE) * 4);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[1:0] !== shadow_mode)
      flag_error($sformatf("mode register reads %0d, expected %0d", prdata[1:0], shadow_mode));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Both byte extremes and two alternating patterns, ending in a message
  // of two bytes.
  task automatic send_extremes();
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h55, 1'b0);
    push_byte(8'hAA, 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // After reset the engine runs the reflected CRC-16 with no write at all.
  task automatic test_reset_mode();
    send_extremes();
  endtask

  task automatic test_each_mode();
    write_reg(REG_CRC_MODE, {30'd0, MODE_CRC8});
    send_extremes();
    write_reg(REG_CRC_MODE, {30'd0, MODE_CCITT});
    send_extremes();
    write_reg(REG_CRC_MODE, {30'd0, MODE_REFL16});
    push_byte(8'h80, 1'b1);
  endtask

  task automatic test_spare_mode();
    write_reg(REG_CRC_MODE, {30'd0, MODE_SPARE});
    push_byte(8'h01, 1'b0);
    push_byte(8'h80, 1'b1);
  endtask

  // A write of the same mode in the middle of a message throws away the
  // bytes already folded in.
  task automatic test_mode_write_mid_message();
    write_reg(REG_CRC_MODE, {30'd0, MODE_CCITT});
    push_byte(8'h31, 1'b0);
    push_byte(8'h32, 1'b0);
    write_reg(REG_CRC_MODE, {30'd0, MODE_CCITT});
    push_byte(8'h33, 1'b1);
  endtask

  // A write to the unused index changes neither the mode nor the running CRC.
  task automatic test_unused_index_write();
    push_byte(8'hC3, 1'b0);
    write_reg(REG_UNUSED, {30'd0, MODE_CRC8});
    push_byte(8'h3C, 1'b1);
  endtask

  // Data bits above the two mode bits are dropped by the register.
  task automatic test_mode_high_bits();
    write_reg(REG_CRC_MODE, 32'hFFFF_FFFD);
    push_byte(8'h7E, 1'b1);
  endtask

  // Random messages, mostly short with the odd long one, over several mode
  // settings. A phase may end in the middle of a message, which the next
  // mode write then discards. One phase runs with no gaps and no stalls.
  task automatic test_random_messages();
    logic [31:0] setting;
    int          len;
    int          pick;
    int          count;
    logic [7:0]  data;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: setting = {30'd0, MODE_REFL16};
        1: setting = {30'd0, MODE_CRC8};
        2: setting = {30'd0, MODE_CCITT};
        3: setting = {30'd0, MODE_SPARE};
        4: setting = $urandom;
        default: setting = $urandom;
      endcase
      if (phase == 4)
        setting[1:0] = MODE_CRC8;
      if (phase == 3)
        write_reg(REG_UNUSED, $urandom);
      write_reg(REG_CRC_MODE, setting);
      quiet = (phase == 2);
      count = 0;
      while (count < PHASE_BYTES) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
        for (int i = 0; i < len && count < PHASE_BYTES; i++) begin
          pick = $urandom_range(0, 15);
          data = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom_range(0, 255));
          push_byte(data, i == len - 1);
          count++;
        end
      end
      quiet = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    shadow_mode  = MODE_REFL16;
    shadow_crc   = start_value(MODE_REFL16);
    error_count  = 0;
    bytes_sent   = 0;
    crcs_checked = 0;
    reg_writes   = 0;
    quiet        = 1'b0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data_byte <= 8'h00;
    in_last_byte <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= 3'd0;
    pwdata       <= 32'd0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_mode();
    test_each_mode();
    test_spare_mode();
    test_mode_write_mid_message();
    test_unused_index_write();
    test_mode_high_bits();
    test_random_messages();
    drain();

    $display("Covered %0d message bytes and %0d CRC words in all modes, the spare code included,",
             bytes_sent, crcs_checked);
    $display("with %0d register writes and random gaps and stalls on both channels.", reg_writes);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
